### rtl/fup_pkg.sv
// ----------------------------------------------------------------------------
// fup_pkg
// Shared types, constants and helper functions for the form body pair
// splitter: result kinds, result bundles and hex digit decoding.
// ----------------------------------------------------------------------------
package fup_pkg;

	// Default width of the per-body pair counter.
	localparam int FUP_COUNT_BITS = 16;

	// Depth of the bundle queue between the front and back parts.
	localparam int FUP_QUEUE_DEPTH = 4;

	// Reset value of the max_fields register.
	localparam logic [15:0] MAX_FIELDS_RST = 16'd10000;

	// Register word indexes on the configuration port.
	localparam logic REG_MAX_FIELDS = 1'b0;

	// Characters with a special meaning in the body.
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Kind of one result.
	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// One result: kind and decoded byte.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} res_t;

	// All results caused by one input item, oldest in slot 0.
	typedef struct packed {
		logic [1:0]     cnt;
		res_t [2:0]     r;
	} bundle_t;

	// True for 0-9, a-f and A-F.
	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) ||
		       ((c >= 8'h61) && (c <= 8'h66)) ||
		       ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	// Value of a hex digit; meaningless for other characters.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	// Append one result to a bundle; a full bundle is left as it is.
	function automatic bundle_t add_res(input bundle_t b, input kind_t k,
	                                    input logic [7:0] d);
		bundle_t nb;
		nb = b;
		if (b.cnt != 2'd3) begin
			nb.r[b.cnt] = '{kind: k, data: d};
			nb.cnt      = b.cnt + 2'd1;
		end
		return nb;
	endfunction

	// Kind of a data byte in the current part of the pair.
	function automatic kind_t part_kind(input logic in_value);
		return in_value ? KIND_VALUE : KIND_KEY;
	endfunction

endpackage

### rtl/form_urlencoded_pair_splitter.sv
// ----------------------------------------------------------------------------
// form_urlencoded_pair_splitter
// Splits a form body into key and value bytes, decoding '+' and percent
// escapes, with a pair-end marker after every non-empty pair.
//
//   Channel   Handshake                 Payload
//   input     push / full               body_byte, body_end
//   result    pop / empty               item_kind, data_byte, last
//   config    psel, penable, pwrite     paddr, pwdata, prdata (max_fields)
//
// An input item is taken and its zero to three results go into a four-bundle
// queue; items can follow each other in every cycle while the queue is not full.
// Results leave at one transfer per cycle while pop is held, so an item with
// three results takes three result transfers; the queue absorbs such bursts.
// full rises only when the bundle queue is full; empty is low while the
// back part holds a result. Reset clears all parse state and sets
// max_fields to 10000.
// ----------------------------------------------------------------------------
module form_urlencoded_pair_splitter #(
	parameter int COUNT_BITS  = fup_pkg::FUP_COUNT_BITS,
	parameter int QUEUE_DEPTH = fup_pkg::FUP_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [7:0]     body_byte,
	input  logic           body_end,
	input  logic           pop,
	output logic           empty,
	output fup_pkg::kind_t item_kind,
	output logic [7:0]     data_byte,
	output logic           last,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import fup_pkg::*;

	logic [15:0] max_fields_q;
	logic        accept;
	bundle_t     f_bundle;
	logic        f_valid;
	bundle_t     q_data;
	logic        q_empty;
	logic        q_rd;
	logic        q_full;

	// Configuration register; writes complete on the access cycle.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fields_q <= MAX_FIELDS_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_FIELDS)) begin
			max_fields_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MAX_FIELDS) begin
			prdata = {16'h0000, max_fields_q};
		end
	end

	// Input transfer.
	assign full   = q_full;
	assign accept = push && !q_full;

	fup_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.body_byte    (body_byte),
		.body_end     (body_end),
		.max_fields   (max_fields_q),
		.bundle       (f_bundle),
		.bundle_valid (f_valid)
	);

	fup_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid),
		.wr_data (f_bundle),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	fup_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_data),
		.q_empty   (q_empty),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.item_kind (item_kind),
		.data_byte (data_byte),
		.last      (last)
	);

endmodule

### rtl/fup_front.sv
// ----------------------------------------------------------------------------
// fup_front
// Front part: holds the parse state of the body and turns each accepted
// byte or body end into a bundle of up to three results, combinationally.
// ----------------------------------------------------------------------------
module fup_front #(
	parameter int COUNT_BITS = fup_pkg::FUP_COUNT_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       body_byte,
	input  logic             body_end,
	input  logic [15:0]      max_fields,
	output fup_pkg::bundle_t bundle,
	output logic             bundle_valid
);
	import fup_pkg::*;

	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	// Escape phase: none, after '%', after '%' and one hex digit.
	typedef enum logic [2:0] {
		PH_NONE = 3'b001,
		PH_PCT  = 3'b010,
		PH_HEX  = 3'b100
	} phase_t;

	phase_t                  phase_q, phase_n;
	logic [7:0]              held_q, held_n;
	logic                    in_value_q, in_value_n;
	logic                    has_q, has_n;
	logic [COUNT_BITS-1:0]   pairs_q, pairs_n;
	logic                    limit_q, limit_n;
	bundle_t                 bun;
	logic                    b_hex;

	assign b_hex = is_hex(body_byte);

	// Next state and results of the current item, in the order of emission.
	always_comb begin
		bun        = '0;
		phase_n    = phase_q;
		held_n     = held_q;
		in_value_n = in_value_q;
		has_n      = has_q;
		pairs_n    = pairs_q;
		limit_n    = limit_q;
		if (body_end) begin
			if (!limit_q) begin
				// Flush a pending escape literally, then close the open pair.
				if (phase_n == PH_PCT) begin
					bun = add_res(bun, part_kind(in_value_n), CH_PCT);
				end else if (phase_n == PH_HEX) begin
					bun = add_res(bun, part_kind(in_value_n), CH_PCT);
					bun = add_res(bun, part_kind(in_value_n), held_n);
				end
				if (has_n) begin
					bun = add_res(bun, KIND_END, 8'h00);
					if (pairs_n != '1) begin
						pairs_n = pairs_n + 1'b1;
					end
					if (CMP_W'(pairs_n) >= CMP_W'(max_fields)) begin
						limit_n = 1'b1;
					end
				end
			end
			phase_n    = PH_NONE;
			held_n     = '0;
			in_value_n = 1'b0;
			has_n      = 1'b0;
			pairs_n    = '0;
			limit_n    = 1'b0;
		end else if (!limit_q) begin
			if ((phase_q == PH_HEX) && b_hex) begin
				// Complete escape: one decoded byte.
				bun = add_res(bun, part_kind(in_value_n),
				              {hex_val(held_q), hex_val(body_byte)});
				phase_n = PH_NONE;
				held_n  = '0;
			end else if ((phase_q == PH_PCT) && b_hex) begin
				held_n  = body_byte;
				phase_n = PH_HEX;
			end else begin
				// Broken escape comes out literally before the byte itself.
				if (phase_n == PH_PCT) begin
					bun = add_res(bun, part_kind(in_value_n), CH_PCT);
				end else if (phase_n == PH_HEX) begin
					bun = add_res(bun, part_kind(in_value_n), CH_PCT);
					bun = add_res(bun, part_kind(in_value_n), held_n);
				end
				phase_n = PH_NONE;
				held_n  = '0;
				// The raw byte: separator, escape start or data.
				if (body_byte == CH_AMP) begin
					if (has_n) begin
						bun = add_res(bun, KIND_END, 8'h00);
						if (pairs_n != '1) begin
							pairs_n = pairs_n + 1'b1;
						end
						if (CMP_W'(pairs_n) >= CMP_W'(max_fields)) begin
							limit_n = 1'b1;
						end
					end
					has_n      = 1'b0;
					in_value_n = 1'b0;
				end else begin
					has_n = 1'b1;
					if ((body_byte == CH_EQ) && !in_value_n) begin
						in_value_n = 1'b1;
					end else if (body_byte == CH_PCT) begin
						phase_n = PH_PCT;
					end else if (body_byte == CH_PLUS) begin
						bun = add_res(bun, part_kind(in_value_n), CH_SPACE);
					end else begin
						bun = add_res(bun, part_kind(in_value_n), body_byte);
					end
				end
			end
		end
	end

	// Parse state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_NONE;
			held_q     <= '0;
			in_value_q <= 1'b0;
			has_q      <= 1'b0;
			pairs_q    <= '0;
			limit_q    <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_n;
			held_q     <= held_n;
			in_value_q <= in_value_n;
			has_q      <= has_n;
			pairs_q    <= pairs_n;
			limit_q    <= limit_n;
		end
	end

	assign bundle       = bun;
	assign bundle_valid = accept && (bun.cnt != 2'd0);

	// A held hex digit exists only while waiting for the second digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEX) |-> (held_q == 8'h00))
	else $error("held hex digit outside second escape phase");

	// While the limit holds, no results leave the front part.
	assert property (@(posedge clk) disable iff (!arst_n)
		limit_q |-> !bundle_valid)
	else $error("results produced after the pair limit");

	// The limit only comes with a pair end.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(limit_q) |-> $past(bundle_valid))
	else $error("limit set without a closed pair");

endmodule

### rtl/fup_queue.sv
// ----------------------------------------------------------------------------
// fup_queue
// Short queue of result bundles between the front and back parts, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module fup_queue #(
	parameter int DEPTH = fup_pkg::FUP_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  fup_pkg::bundle_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output fup_pkg::bundle_t rd_data,
	output logic             empty
);
	import fup_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The front part never writes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(wr_en && full))
	else $error("write into full bundle queue");

	// The back part never reads an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) !(rd_en && empty))
	else $error("read from empty bundle queue");

	// Every bundle in the queue carries at least one result.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_data.cnt != 2'd0))
	else $error("empty bundle written");

endmodule

### rtl/fup_back.sv
// ----------------------------------------------------------------------------
// fup_back
// Back part: takes bundles from the queue and hands out their results one
// transfer at a time from a registered bundle, marking the last of each.
// ----------------------------------------------------------------------------
module fup_back (
	input  logic             clk,
	input  logic             arst_n,
	input  fup_pkg::bundle_t q_data,
	input  logic             q_empty,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output fup_pkg::kind_t   item_kind,
	output logic [7:0]       data_byte,
	output logic             last
);
	import fup_pkg::*;

	bundle_t     bun_q;
	logic        valid_q;
	logic [1:0]  idx_q;
	logic        take;
	logic        finish;
	logic        load;
	res_t        cur;

	assign cur       = bun_q.r[idx_q];
	assign item_kind = cur.kind;
	assign data_byte = cur.data;
	assign last      = (idx_q == (bun_q.cnt - 2'd1));
	assign empty     = !valid_q;

	// A new bundle is loaded as the previous one hands out its last result.
	assign take   = pop && valid_q;
	assign finish = take && last;
	assign load   = (!valid_q || finish) && !q_empty;
	assign q_rd   = load;

	// Bundle register; payload needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			bun_q <= q_data;
		end
	end

	// Valid flag and result index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (finish) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// A pair end always carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (item_kind == KIND_END)) |-> (data_byte == 8'h00))
	else $error("pair end with non-zero data");

	// The index stays inside the loaded bundle.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q < bun_q.cnt))
	else $error("result index beyond bundle");

	// A result that is not taken stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(idx_q)))
	else $error("waiting result changed");

endmodule

### verif/form_urlencoded_pair_splitter_checker.sv
// ----------------------------------------------------------------------------
// Form body pair splitter checker
// Watches the input, result and configuration channels of the pair splitter.
// Every accepted input transfer is decoded by an independent predictor into
// the key bytes, value bytes and pair-end markers it should produce. Every
// accepted result transfer is compared with the oldest of those. The number
// of failures and the number of results still awaited go to the testbench top.
// ----------------------------------------------------------------------------
module form_urlencoded_pair_splitter_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  logic [7:0]      body_byte,
	input  logic            body_end,
	input  logic            pop,
	input  logic            empty,
	input  fup_pkg::kind_t  item_kind,
	input  logic [7:0]      data_byte,
	input  logic            last,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	input  logic            pready,
	output int              mismatches,
	output int              awaited
);

	timeunit 1ns;
	timeprecision 1ps;

	import fup_pkg::*;

	// Progress through a percent escape.
	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_stage_t;

	// One decoded result as the block should present it.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} decoded_t;

	// Decoder state for the body in progress.
	esc_stage_t                  esc_stage;
	logic [7:0]                  first_digit;
	logic                        in_value;
	logic                        pair_open;
	logic [FUP_COUNT_BITS-1:0]   pair_count;
	logic                        fields_full;
	logic [15:0]                 field_limit;

	// Results of the transfer being decoded, then all results still awaited.
	decoded_t                    step_buf [3];
	int                          step_n;
	decoded_t                    awaited_results [$];
	int                          fail_tally;

	// Numeric value of a hex digit, or -1 for any other byte.
	function automatic int digit_value(input logic [7:0] c);
		if (c inside {[8'h30:8'h39]}) begin
			return int'(c) - 'h30;
		end
		if (c inside {[8'h41:8'h46]}) begin
			return int'(c) - 'h41 + 10;
		end
		if (c inside {[8'h61:8'h66]}) begin
			return int'(c) - 'h61 + 10;
		end
		return -1;
	endfunction

	// Queue one result of the current transfer; at most three can arise.
	task automatic add_result(input kind_t k, input logic [7:0] d);
		if (step_n < 3) begin
			step_buf[step_n] = '{kind: k, data: d, last: 1'b0};
			step_n++;
		end
	endtask

	// A decoded byte belongs to whichever part of the pair is open.
	task automatic add_part_byte(input logic [7:0] d);
		add_result(in_value ? KIND_VALUE : KIND_KEY, d);
	endtask

	// An unfinished escape is passed through as the raw characters seen.
	task automatic flush_escape();
		if (esc_stage == ESC_PCT) begin
			add_part_byte(CH_PCT);
		end else if (esc_stage == ESC_DIGIT) begin
			add_part_byte(CH_PCT);
			add_part_byte(first_digit);
		end
		esc_stage   = ESC_NONE;
		first_digit = 8'h00;
	endtask

	// Only a pair with some raw content is closed and counted.
	task automatic close_pair();
		if (pair_open) begin
			add_result(KIND_END, 8'h00);
			if (pair_count != '1) begin
				pair_count++;
			end
			if (pair_count >= field_limit) begin
				fields_full = 1'b1;
			end
		end
		pair_open = 1'b0;
		in_value  = 1'b0;
	endtask

	// A raw byte outside any escape.
	task automatic plain_byte(input logic [7:0] b);
		if (b == CH_AMP) begin
			close_pair();
		end else begin
			pair_open = 1'b1;
			if (b == CH_EQ && !in_value) begin
				in_value = 1'b1;
			end else if (b == CH_PCT) begin
				esc_stage = ESC_PCT;
			end else if (b == CH_PLUS) begin
				add_part_byte(CH_SPACE);
			end else begin
				add_part_byte(b);
			end
		end
	endtask

	// Body state returns to its start; the field limit is kept.
	task automatic clear_body();
		esc_stage   = ESC_NONE;
		first_digit = 8'h00;
		in_value    = 1'b0;
		pair_open   = 1'b0;
		pair_count  = '0;
		fields_full = 1'b0;
	endtask

	// Decode one input transfer and append its results to the awaited list.
	task automatic decode_transfer(input logic [7:0] b, input logic fin);
		step_n = 0;
		if (fin) begin
			if (!fields_full) begin
				flush_escape();
				close_pair();
			end
			clear_body();
		end else if (!fields_full) begin
			case (esc_stage)
				ESC_PCT: begin
					if (digit_value(b) >= 0) begin
						first_digit = b;
						esc_stage   = ESC_DIGIT;
					end else begin
						flush_escape();
						plain_byte(b);
					end
				end
				ESC_DIGIT: begin
					if (digit_value(b) >= 0) begin
						add_part_byte(8'(digit_value(first_digit) * 16 + digit_value(b)));
						esc_stage   = ESC_NONE;
						first_digit = 8'h00;
					end else begin
						flush_escape();
						plain_byte(b);
					end
				end
				default: begin
					plain_byte(b);
				end
			endcase
		end
		if (step_n > 0) begin
			step_buf[step_n-1].last = 1'b1;
		end
		for (int i = 0; i < step_n; i++) begin
			awaited_results.push_back(step_buf[i]);
		end
	endtask

	// Result transfers are checked before the input transfer of the same edge
	// is decoded; the block cannot return a result in the cycle it takes the item.
	always @(posedge clk) begin
		decoded_t want;
		if (!arst_n) begin
			clear_body();
			field_limit = MAX_FIELDS_RST;
			fail_tally  = 0;
			awaited_results.delete();
		end else begin
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with none expected: item_kind %0d data_byte %02h",
					       item_kind, data_byte);
					fail_tally++;
				end else begin
					want = awaited_results.pop_front();
					if (item_kind != want.kind) begin
						$error("item_kind: expected %0d, got %0d", want.kind, item_kind);
						fail_tally++;
					end
					if (data_byte != want.data) begin
						$error("data_byte: expected %02h, got %02h", want.data, data_byte);
						fail_tally++;
					end
					if (last != want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						fail_tally++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == {REG_MAX_FIELDS, 2'b00}) begin
				field_limit = pwdata[15:0];
			end
			if (push && !full) begin
				decode_transfer(body_byte, body_end);
			end
		end
		awaited    <= awaited_results.size();
		mismatches <= fail_tally;
	end

endmodule

### verif/form_urlencoded_pair_splitter_test.sv
// ----------------------------------------------------------------------------
// Form body pair splitter testbench
// Drives form bodies into the pair splitter through its queue-style input
// and drains the results with random stalls, including one long hold-off
// that fills the block. A directed body covers the escape corner cases, then
// random bodies run under several field limits written over the register
// port. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module form_urlencoded_pair_splitter_test;

	timeunit 1ns;
	timeprecision 1ps;

	import fup_pkg::*;

	// Opening body: both hex cases, '+', escapes cut by '=', '&' and body end,
	// escapes broken by a non-hex byte, a later '=', an empty pair and a pair
	// without '='.
	localparam string OPENING    = "%6a%4F+%4=a=%zb%4g%4&&x%";
	localparam int    HOLD_CYCLES = 60;
	localparam int    DRAIN_CYCLES = 12;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  body_byte;
	logic        body_end;
	logic        pop;
	logic        empty;
	kind_t       item_kind;
	logic [7:0]  data_byte;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          awaited;
	int          items_sent;
	bit          sender_idles;
	bit          receiver_idles;
	bit          hold_results;

	form_urlencoded_pair_splitter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.body_byte (body_byte),
		.body_end  (body_end),
		.pop       (pop),
		.empty     (empty),
		.item_kind (item_kind),
		.data_byte (data_byte),
		.last      (last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	form_urlencoded_pair_splitter_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.body_byte  (body_byte),
		.body_end   (body_end),
		.pop        (pop),
		.empty      (empty),
		.item_kind  (item_kind),
		.data_byte  (data_byte),
		.last       (last),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit.
	initial begin
		#200us;
		$display("[form_urlencoded_pair_splitter] ERROR");
		$finish;
	end

	// Offer one input transfer after an optional gap and wait until it is taken.
	task automatic send_item(input logic [7:0] b, input logic fin);
		int gap;
		gap = sender_idles ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		body_byte <= b;
		body_end  <= fin;
		push      <= 1'b1;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// A hex digit character in either case.
	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) begin
			return 8'(8'h30 + v);
		end
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	// One piece of key or value text: plain characters, '+', escapes good
	// and broken, stray bytes and extra '=' signs.
	task automatic send_token();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
		end else if (pick < 48) begin
			send_item(8'($urandom_range(8'h30, 8'h39)), 1'b0);
		end else if (pick < 58) begin
			send_item(CH_PLUS, 1'b0);
		end else if (pick < 76) begin
			send_item(CH_PCT, 1'b0);
			send_item(hex_char(), 1'b0);
			send_item(hex_char(), 1'b0);
		end else if (pick < 86) begin
			// An escape cut short by a non-hex byte, a separator or another '%'.
			send_item(CH_PCT, 1'b0);
			if ($urandom_range(0, 1)) begin
				send_item(hex_char(), 1'b0);
			end
			case ($urandom_range(0, 3))
				0: send_item(8'($urandom_range(8'h67, 8'h7A)), 1'b0);
				1: send_item(CH_AMP, 1'b0);
				2: send_item(CH_EQ, 1'b0);
				default: send_item(CH_PCT, 1'b0);
			endcase
		end else if (pick < 94) begin
			send_item(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_item(CH_EQ, 1'b0);
		end
	endtask

	// A well-formed body of a few pairs with random content, then body end.
	task automatic send_random_body();
		int pairs;
		pairs = $urandom_range(0, 4);
		for (int p = 0; p < pairs; p++) begin
			if (p != 0) begin
				send_item(CH_AMP, 1'b0);
			end
			if ($urandom_range(0, 5) == 0) begin
				send_item(CH_AMP, 1'b0);
			end
			repeat ($urandom_range(0, 4)) send_token();
			if ($urandom_range(0, 4) != 0) begin
				send_item(CH_EQ, 1'b0);
				repeat ($urandom_range(0, 4)) send_token();
			end
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Stop offering, wait for every awaited result, then let the pipeline drain.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write: setup cycle then access cycle.
	task automatic write_max_fields(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_MAX_FIELDS, 2'b00};
		pwdata  <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly well-formed bodies, some noise with random body ends.
	task automatic run_phase(input int count, input bit s_idle, input bit r_idle);
		int target;
		sender_idles   = s_idle;
		receiver_idles = r_idle;
		target         = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) != 0) begin
				send_random_body();
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				end
			end
		end
		settle();
	endtask

	// Result side: random stalls, or one long hold-off when asked for.
	initial begin
		int gap;
		pop = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end else if (receiver_idles) begin
				gap = $urandom_range(0, 3);
				if (gap != 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n         = 1'b0;
		push           = 1'b0;
		body_byte      = 8'h00;
		body_end       = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		items_sent     = 0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		hold_results   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed body under the reset field limit; it ends on a lone '%',
		// followed by a body end on an empty body.
		for (int i = 0; i < OPENING.len(); i++) begin
			send_item(OPENING[i], 1'b0);
		end
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b1);
		run_phase(20, 1'b1, 1'b1);

		// Lowest limit: everything after the first pair is dropped.
		write_max_fields(16'd1);
		run_phase(25, 1'b1, 1'b1);

		// Highest limit, back to back, with the result side held off for a while.
		write_max_fields(16'hFFFF);
		hold_results = 1'b1;
		run_phase(25, 1'b0, 1'b0);

		// A zero limit acts as one.
		write_max_fields(16'd0);
		run_phase(25, 1'b1, 1'b0);

		write_max_fields(16'd2);
		run_phase(25, 1'b0, 1'b1);

		write_max_fields(16'($urandom_range(3, 6)));
		run_phase(25, 1'b1, 1'b1);

		if (mismatches == 0) begin
			$display("[form_urlencoded_pair_splitter] OK");
		end else begin
			$display("[form_urlencoded_pair_splitter] ERROR");
		end
		$finish;
	end

endmodule
